>>> rtl/vqm_pkg.sv
package vqm_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int NUM_QUEUES  = 4;

  // ring positions never exceed 256 entries, descriptor ids are 8 bits
  localparam int SIZE_LIM  = (QUEUE_DEPTH < 256) ? QUEUE_DEPTH : 256;
  localparam int DIDX_W    = $clog2(SIZE_LIM);
  localparam int QIDX_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int MEM_DEPTH = NUM_QUEUES * SIZE_LIM;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NO_USED  = 2'd2;
  localparam logic [1:0] ST_BAD_ID   = 2'd3;

  typedef enum logic [2:0] {
    K_ATTACH = 3'd0,
    K_CHAIN  = 3'd1,
    K_KICK   = 3'd2,
    K_POST   = 3'd3,
    K_DETACH = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLEAR = 4'b0010,
    S_READ  = 4'b0100,
    S_DET   = 4'b1000
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  queue;
    logic [63:0] buf_addr;
    logic [31:0] buf_len;
    logic        is_write;
    logic [8:0]  chain_count;
    logic        chain_first;
    logic        chain_last;
    logic [31:0] used_id;
    logic [31:0] used_len;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        notify;
    logic [7:0]  desc_index;
    logic [63:0] out_addr;
    logic [31:0] out_size;
    logic [31:0] out_data_len;
    logic [15:0] avail_index;
  } res_t;

  typedef struct packed {
    logic [63:0]       addr;
    logic [31:0]       len;
    logic [DIDX_W-1:0] link;
  } desc_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] len;
  } used_t;

  // clamp to 2..SIZE_LIM, round down to a power of two
  function automatic logic [8:0] eff_size(input logic [8:0] v);
    logic [8:0] c;
    logic [8:0] p;
    c = v;
    p = 9'd1;
    if (c < 9'd2) c = 9'd2;
    if (c > 9'(SIZE_LIM)) c = 9'(SIZE_LIM);
    for (int b = 0; b < 9; b++) begin
      if (c[b]) p = 9'(1 << b);
    end
    return p;
  endfunction

endpackage

>>> rtl/vqm_if.sv
interface vqm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  queue;
  logic [63:0] buf_addr;
  logic [31:0] buf_len;
  logic        is_write;
  logic [8:0]  chain_count;
  logic        chain_first;
  logic        chain_last;
  logic [31:0] used_id;
  logic [31:0] used_len;

  modport source (output valid, kind, queue, buf_addr, buf_len, is_write, chain_count,
                  chain_first, chain_last, used_id, used_len, input ready);
  modport sink (input valid, kind, queue, buf_addr, buf_len, is_write, chain_count,
                chain_first, chain_last, used_id, used_len, output ready);
endinterface

interface vqm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        notify;
  logic [7:0]  desc_index;
  logic [63:0] out_addr;
  logic [31:0] out_size;
  logic [31:0] out_data_len;
  logic [15:0] avail_index;

  modport source (output valid, status, notify, desc_index, out_addr, out_size,
                  out_data_len, avail_index, input ready);
  modport sink (input valid, status, notify, desc_index, out_addr, out_size,
                out_data_len, avail_index, output ready);
endinterface

>>> rtl/virtqueue_descriptor_ring_manager_unit.sv
// Results: attach, chain element, kick, post and error results are formed in S_READ and
//   registered into the output register; a successful detach passes through S_DET first.
// Items: a new item is accepted only in S_IDLE, once the previous result has committed; each
//   item reads the RAMs when accepted and writes back when its result commits.
// Reset and every cfg write clear all 1024 descriptor table entries (one entry per
//   cycle) and restore all queues; no item is accepted until that pass ends.
module virtqueue_descriptor_ring_manager_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [8:0]       cfg_wdata,
  vqm_in_if.sink           in_ch,
  vqm_out_if.source        out_ch
);

  localparam int DIDX_W = vqm_pkg::DIDX_W;
  localparam int QIDX_W = vqm_pkg::QIDX_W;
  localparam int MEM_AW = vqm_pkg::MEM_AW;
  localparam int NQ     = vqm_pkg::NUM_QUEUES;

  vqm_pkg::state_t state_r, state_nxt;
  logic [MEM_AW-1:0] clr_cnt_r;
  logic [8:0]        size_r;
  logic [DIDX_W-1:0] mask;

  logic [DIDX_W-1:0] free_head_r [NQ];
  logic [8:0]        free_count_r [NQ];
  logic [8:0]        pending_r [NQ];
  logic [15:0]       avail_idx_r [NQ];
  logic [15:0]       used_idx_r [NQ];
  logic [15:0]       last_used_r [NQ];
  logic [DIDX_W-1:0] chain_prev_r, chain_prev_nxt;
  logic              chain_rej_r, chain_rej_nxt;

  vqm_pkg::item_t item_r, item_in;
  logic           q_ok_r;
  logic [QIDX_W-1:0] qi, qin;

  vqm_pkg::res_t  out_r, res;
  logic           out_valid_r;
  logic           out_free, commit, accept, qupd;

  logic [DIDX_W-1:0] fh_nxt;
  logic [8:0]        fc_nxt, pend_nxt;
  logic [15:0]       avail_nxt, uidx_nxt, lu_nxt;

  logic              desc_we, desc_re, used_we, used_re;
  logic [MEM_AW-1:0] desc_waddr, desc_raddr, used_waddr, used_raddr;
  vqm_pkg::desc_t    desc_wdata, desc_rdata;
  vqm_pkg::used_t    used_wdata, used_rdata;

  logic [DIDX_W-1:0] d_head, det_id;
  logic [8:0]        fc;
  logic              rej_eff;

  vqm_ram #(.WIDTH($bits(vqm_pkg::desc_t)), .DEPTH(vqm_pkg::MEM_DEPTH)) u_desc_ram (
    .clk(clk), .we(desc_we), .waddr(desc_waddr), .wdata(desc_wdata),
    .re(desc_re), .raddr(desc_raddr), .rdata(desc_rdata)
  );

  vqm_ram #(.WIDTH($bits(vqm_pkg::used_t)), .DEPTH(vqm_pkg::MEM_DEPTH)) u_used_ram (
    .clk(clk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
    .re(used_re), .raddr(used_raddr), .rdata(used_rdata)
  );

  assign item_in = '{kind: in_ch.kind, queue: in_ch.queue, buf_addr: in_ch.buf_addr,
                     buf_len: in_ch.buf_len, is_write: in_ch.is_write,
                     chain_count: in_ch.chain_count, chain_first: in_ch.chain_first,
                     chain_last: in_ch.chain_last, used_id: in_ch.used_id,
                     used_len: in_ch.used_len};

  assign mask     = DIDX_W'(size_r - 9'd1);
  assign in_ch.ready = (state_r == vqm_pkg::S_IDLE);
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign qin      = QIDX_W'(in_ch.queue);
  assign qi       = QIDX_W'(item_r.queue);
  assign fc       = free_count_r[qi];
  assign d_head   = free_head_r[qi] & mask;
  assign det_id   = used_rdata.id[DIDX_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    desc_we        = 1'b0;
    desc_waddr     = '0;
    desc_wdata     = '0;
    desc_re        = 1'b0;
    desc_raddr     = '0;
    used_we        = 1'b0;
    used_waddr     = '0;
    used_wdata     = '0;
    used_re        = 1'b0;
    used_raddr     = '0;
    commit         = 1'b0;
    qupd           = 1'b0;
    res            = '0;
    fh_nxt         = free_head_r[qi];
    fc_nxt         = fc;
    pend_nxt       = pending_r[qi];
    avail_nxt      = avail_idx_r[qi];
    uidx_nxt       = used_idx_r[qi];
    lu_nxt         = last_used_r[qi];
    chain_prev_nxt = chain_prev_r;
    chain_rej_nxt  = chain_rej_r;
    rej_eff        = item_r.chain_first ? (fc < item_r.chain_count) : chain_rej_r;

    unique case (state_r)
      vqm_pkg::S_CLEAR: begin
        desc_we    = 1'b1;
        desc_waddr = clr_cnt_r;
        desc_wdata = '{addr: '0, len: '0, link: DIDX_W'(clr_cnt_r[DIDX_W-1:0] + 1'b1)};
        if (clr_cnt_r == MEM_AW'(vqm_pkg::MEM_DEPTH - 1)) begin
          state_nxt = vqm_pkg::S_IDLE;
        end
      end
      vqm_pkg::S_IDLE: begin
        if (accept) begin
          desc_re    = 1'b1;
          desc_raddr = {qin, free_head_r[qin] & mask};
          used_re    = 1'b1;
          used_raddr = {qin, last_used_r[qin][DIDX_W-1:0] & mask};
          state_nxt  = vqm_pkg::S_READ;
        end
      end
      vqm_pkg::S_READ: begin
        res.avail_index = q_ok_r ? avail_idx_r[qi] : 16'd0;
        if (!q_ok_r) begin
          commit = out_free;
        end else begin
          case (vqm_pkg::kind_t'(item_r.kind))
            vqm_pkg::K_ATTACH: begin
              commit = out_free;
              if (fc == 9'd0) begin
                res.status = vqm_pkg::ST_NO_SPACE;
                res.notify = 1'b1;
              end else begin
                desc_we        = commit;
                desc_waddr     = {qi, d_head};
                desc_wdata     = '{addr: item_r.buf_addr, len: item_r.buf_len,
                                   link: desc_rdata.link};
                qupd           = 1'b1;
                fh_nxt         = desc_rdata.link & mask;
                fc_nxt         = fc - 9'd1;
                pend_nxt       = pending_r[qi] + 9'd1;
                res.desc_index = 8'(d_head);
              end
            end
            vqm_pkg::K_CHAIN: begin
              commit        = out_free;
              chain_rej_nxt = rej_eff;
              if (rej_eff) begin
                res.status = vqm_pkg::ST_NO_SPACE;
                res.notify = item_r.chain_first;
              end else if (fc == 9'd0) begin
                chain_rej_nxt = 1'b1;
                res.status    = vqm_pkg::ST_NO_SPACE;
                res.notify    = 1'b1;
              end else begin
                desc_we        = commit;
                desc_waddr     = {qi, d_head};
                desc_wdata     = '{addr: item_r.buf_addr, len: item_r.buf_len,
                                   link: item_r.chain_first ? '0 : (chain_prev_r & mask)};
                qupd           = 1'b1;
                fh_nxt         = desc_rdata.link & mask;
                fc_nxt         = fc - 9'd1;
                chain_prev_nxt = d_head;
                if (item_r.chain_last) begin
                  pend_nxt = pending_r[qi] + 9'd1;
                end
                res.desc_index = 8'(d_head);
              end
            end
            vqm_pkg::K_KICK: begin
              commit          = out_free;
              qupd            = 1'b1;
              avail_nxt       = avail_idx_r[qi] + 16'(pending_r[qi]);
              pend_nxt        = 9'd0;
              res.notify      = 1'b1;
              res.avail_index = avail_nxt;
            end
            vqm_pkg::K_POST: begin
              commit     = out_free;
              used_we    = commit;
              used_waddr = {qi, used_idx_r[qi][DIDX_W-1:0] & mask};
              used_wdata = '{id: item_r.used_id, len: item_r.used_len};
              qupd       = 1'b1;
              uidx_nxt   = used_idx_r[qi] + 16'd1;
            end
            vqm_pkg::K_DETACH: begin
              if (last_used_r[qi] == used_idx_r[qi]) begin
                commit     = out_free;
                res.status = vqm_pkg::ST_NO_USED;
              end else if (used_rdata.id >= 32'(size_r)) begin
                commit     = out_free;
                res.status = vqm_pkg::ST_BAD_ID;
              end else begin
                // fetch the returned descriptor; the detach finishes in S_DET
                desc_re    = 1'b1;
                desc_raddr = {qi, det_id};
                state_nxt  = vqm_pkg::S_DET;
              end
            end
            default: begin
              commit = out_free;
            end
          endcase
        end
        if (commit) begin
          state_nxt = vqm_pkg::S_IDLE;
        end
      end
      vqm_pkg::S_DET: begin
        commit           = out_free;
        res.avail_index  = avail_idx_r[qi];
        res.desc_index   = 8'(det_id);
        res.out_addr     = desc_rdata.addr;
        res.out_size     = desc_rdata.len;
        res.out_data_len = used_rdata.len;
        desc_we          = commit;
        desc_waddr       = {qi, det_id};
        desc_wdata       = '{addr: '0, len: desc_rdata.len, link: d_head};
        qupd             = 1'b1;
        fh_nxt           = det_id;
        lu_nxt           = last_used_r[qi] + 16'd1;
        if (fc < size_r) begin
          fc_nxt = fc + 9'd1;
        end
        if (commit) begin
          state_nxt = vqm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = vqm_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      state_r      <= vqm_pkg::S_CLEAR;
      clr_cnt_r    <= '0;
      size_r       <= vqm_pkg::eff_size(rst_n ? cfg_wdata : 9'd256);
      chain_prev_r <= '0;
      chain_rej_r  <= 1'b0;
      for (int q = 0; q < NQ; q++) begin
        free_head_r[q]  <= '0;
        free_count_r[q] <= vqm_pkg::eff_size(rst_n ? cfg_wdata : 9'd256);
        pending_r[q]    <= '0;
        avail_idx_r[q]  <= '0;
        used_idx_r[q]   <= '0;
        last_used_r[q]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == vqm_pkg::S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (commit) begin
        chain_prev_r <= chain_prev_nxt;
        chain_rej_r  <= chain_rej_nxt;
        if (qupd) begin
          free_head_r[qi]  <= fh_nxt;
          free_count_r[qi] <= fc_nxt;
          pending_r[qi]    <= pend_nxt;
          avail_idx_r[qi]  <= avail_nxt;
          used_idx_r[qi]   <= uidx_nxt;
          last_used_r[qi]  <= lu_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_in;
      q_ok_r <= (32'(in_ch.queue) < NQ);
    end
    if (commit) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.notify       = out_r.notify;
  assign out_ch.desc_index   = out_r.desc_index;
  assign out_ch.out_addr     = out_r.out_addr;
  assign out_ch.out_size     = out_r.out_size;
  assign out_ch.out_data_len = out_r.out_data_len;
  assign out_ch.avail_index  = out_r.avail_index;

`ifndef ASSERT_OFF
  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !cfg_we |=> state_r == vqm_pkg::S_READ)
    else $error("accepted item did not start its read");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (!out_valid_r || out_ch.ready))
    else $error("result overwrote an untaken result");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vqm_pkg::S_READ |-> free_count_r[qi] <= size_r)
    else $error("free count above queue size");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vqm_pkg::S_CLEAR && clr_cnt_r == MEM_AW'(vqm_pkg::MEM_DEPTH - 1) && !cfg_we
    |=> state_r == vqm_pkg::S_IDLE)
    else $error("clearing pass did not end");

  a_detach_mem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vqm_pkg::S_DET |-> $past(state_r) == vqm_pkg::S_READ ||
                                  $past(state_r) == vqm_pkg::S_DET)
    else $error("detach finish without descriptor read");
`endif

endmodule

>>> rtl/vqm_ram.sv
module vqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
